/* rtl/core/laser_scan_polar_to_cartesian_macros.svh */
// Assertion macros for the laser scan polar-to-cartesian converter.
// Included by the top level; no other dependencies.
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LSP2C_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsp2c assertion failed");

// fixed-delay implication
`define LSP2C_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("lsp2c latency assertion failed");

// the cause must have held earlier, as sampled by $past
`define LSP2C_ASSERT_PAST(label, clk, rst, ante, cause, n) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> $past(cause, n)) \
    else $error("lsp2c history assertion failed");

`else

`define LSP2C_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSP2C_ASSERT_DELAY(label, clk, rst, ante, n, cons)
`define LSP2C_ASSERT_PAST(label, clk, rst, ante, cause, n)

`endif

`endif

/* rtl/core/lsp2c_pkg.sv */
// Shared types and constants of the laser scan polar-to-cartesian converter.
// No dependencies.
package lsp2c_pkg;

  // field widths
  localparam int RANGE_W = 20;
  localparam int IDX_W   = 11;
  localparam int ANG_W   = 21;
  localparam int STEP_W  = 28;
  localparam int DIST_W  = 20;
  localparam int POS_W   = 21;
  localparam int THETA_W = 19;

  // internal widths
  localparam int PROD_W  = IDX_W + STEP_W;   // index times step
  localparam int ANGF_W  = 41;               // full beat angle, 2^-20 deg
  localparam int XY_W    = 36;               // CORDIC x/y, 14 extra fraction bits
  localparam int Z_W     = 29;               // CORDIC residual angle
  localparam int MAG_W   = 29;               // clamped angle magnitude
  localparam int MAX_CELLS = 24;

  // range gate floor: 0.01 m
  localparam logic [RANGE_W-1:0] MIN_RANGE = 20'd40;

  // angle constants in 2^-20 deg
  localparam logic [Z_W-1:0] DEG90  = 29'd94371840;
  localparam logic [Z_W-1:0] DEG180 = 29'd188743680;
  localparam logic [Z_W-1:0] DEG270 = 29'd283115520;
  localparam logic [Z_W-1:0] DEG360 = 29'd377487360;

  // 360 deg = 45 * 2^23: reduce the high part modulo 45
  localparam int MOD_LOW_W = 23;
  localparam int MOD_HI_W  = ANGF_W - MOD_LOW_W;  // 18
  localparam int MOD_U_W   = MOD_HI_W + 1;        // biased, non-negative
  localparam int MOD_Q_W   = 13;
  localparam int MOD_SHIFT = 24;
  localparam logic [MOD_U_W-1:0] MOD_BIAS  = 19'd131085;  // 45 * 2913
  localparam logic [MOD_U_W-1:0] MOD_RECIP = 19'd372828;  // ceil(2^24 / 45)
  localparam logic [MOD_U_W-1:0] MOD_DIV   = 19'd45;

  // scale factors
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;
  localparam logic [MAG_W-1:0] THETA_CLAMP = 29'd268435456;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_ANGLE    = 3'd0,
    REG_END_ANGLE      = 3'd1,
    REG_ANGLE_STEP     = 3'd2,
    REG_SCAN_DIRECTION = 3'd3,
    REG_MIN_DISTANCE   = 3'd4,
    REG_MAX_DISTANCE   = 3'd5
  } cfg_reg_t;

  // payload handed from cell to cell
  typedef struct packed {
    logic                      keep;
    logic                      flip;
    logic signed [THETA_W-1:0] theta;
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [Z_W-1:0]     z;
  } cell_beat_t;

  // atan(2^-i) in 2^-20 deg
  function automatic logic signed [Z_W-1:0] atan_q20(input int i);
    case (i)
      0:  return 29'sd47185920;
      1:  return 29'sd27855475;
      2:  return 29'sd14718068;
      3:  return 29'sd7471121;
      4:  return 29'sd3750058;
      5:  return 29'sd1876857;
      6:  return 29'sd938658;
      7:  return 29'sd469357;
      8:  return 29'sd234682;
      9:  return 29'sd117342;
      10: return 29'sd58671;
      11: return 29'sd29335;
      12: return 29'sd14668;
      13: return 29'sd7334;
      14: return 29'sd3667;
      15: return 29'sd1833;
      16: return 29'sd917;
      17: return 29'sd458;
      18: return 29'sd229;
      19: return 29'sd115;
      20: return 29'sd57;
      21: return 29'sd29;
      22: return 29'sd14;
      23: return 29'sd7;
      default: return 29'sd0;
    endcase
  endfunction

endpackage

/* rtl/core/lsp2c_front.sv */
// Front end: range gate, beam angle, modulo-360 fold, theta and CORDIC seed.
// Six register stages; depends on lsp2c_pkg.
module lsp2c_front import lsp2c_pkg::*; #(
  parameter int MAX_SCAN_POINTS = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [RANGE_W-1:0]        range_sample,
  input  logic [IDX_W-1:0]          sample_index,
  input  logic signed [ANG_W-1:0]   start_angle,
  input  logic signed [ANG_W-1:0]   end_angle,
  input  logic [STEP_W-1:0]         angle_step,
  input  logic                      scan_direction,
  input  logic [DIST_W-1:0]         min_distance,
  input  logic [DIST_W-1:0]         max_distance,
  output logic                      beat_valid,
  output cell_beat_t                beat
);

  localparam logic signed [ANGF_W-1:0] CLAMP_POS = 41'sd268435456;
  localparam logic signed [ANGF_W-1:0] CLAMP_NEG = -41'sd268435456;

  // stage valids
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;

  // stage payloads
  logic                     s1_keep, s2_keep, s3_keep, s4_keep, s5_keep;
  logic [RANGE_W-1:0]       s1_range, s2_range, s3_range, s4_range, s5_range;
  logic [IDX_W-1:0]         s1_idx;
  logic [PROD_W-1:0]        s2_prod;
  logic signed [ANGF_W-1:0] s3_ang;
  logic [MOD_U_W-1:0]       s4_u;
  logic [MOD_Q_W-1:0]       s4_q;
  logic [MOD_LOW_W-1:0]     s4_low;
  logic [MAG_W-1:0]         s4_mag;
  logic                     s4_neg, s5_neg;
  logic [Z_W-1:0]           s5_a;
  logic [55:0]              s5_thp;

  // combinational helpers
  logic                     gate;
  logic signed [ANGF_W-1:0] base_ext, prod_ext, ang_next;
  logic [MOD_U_W-1:0]       u_next;
  logic [2*MOD_U_W-1:0]     q_prod;
  logic [MAG_W-1:0]         mag_next;
  logic                     neg_next;
  logic [MOD_U_W-1:0]       rem_full;
  logic signed [Z_W:0]      a_ext;
  logic signed [Z_W-1:0]    z_next;
  logic                     flip_next;
  logic [49:0]              x_prod;
  logic [56:0]              th_sum;
  logic [20:0]              th_mag;
  logic signed [21:0]       th_s;
  logic signed [THETA_W-1:0] th_next;

  // stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      s1_valid   <= accept;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      s4_valid   <= s3_valid;
      s5_valid   <= s4_valid;
      beat_valid <= s5_valid;
    end
  end

  // stage 1: range and index gate
  assign gate = (range_sample > MIN_RANGE) && (range_sample > min_distance) &&
                (range_sample < max_distance) &&
                (32'(sample_index) < MAX_SCAN_POINTS);

  always_ff @(posedge clk) begin
    s1_keep  <= gate;
    s1_range <= range_sample;
    s1_idx   <= sample_index;
  end

  // stage 2: index times step
  always_ff @(posedge clk) begin
    s2_keep  <= s1_keep;
    s2_range <= s1_range;
    s2_prod  <= PROD_W'(s1_idx) * PROD_W'(angle_step);
  end

  // stage 3: beam angle in 2^-20 deg
  always_comb begin
    if (scan_direction) begin
      base_ext = {{(ANGF_W-ANG_W-8){end_angle[ANG_W-1]}}, end_angle, 8'd0};
    end else begin
      base_ext = {{(ANGF_W-ANG_W-8){start_angle[ANG_W-1]}}, start_angle, 8'd0};
    end
    prod_ext = $signed({{(ANGF_W-PROD_W){1'b0}}, s2_prod});
    ang_next = scan_direction ? (base_ext - prod_ext) : (base_ext + prod_ext);
  end

  always_ff @(posedge clk) begin
    s3_keep  <= s2_keep;
    s3_range <= s2_range;
    s3_ang   <= ang_next;
  end

  // stage 4: quotient of the high part by 45, clamped theta magnitude
  always_comb begin
    u_next = {s3_ang[ANGF_W-1], s3_ang[ANGF_W-1:MOD_LOW_W]} + MOD_BIAS;
    q_prod = (2*MOD_U_W)'(u_next) * (2*MOD_U_W)'(MOD_RECIP);
    if (s3_ang > CLAMP_POS) begin
      mag_next = THETA_CLAMP;
      neg_next = 1'b0;
    end else if (s3_ang < CLAMP_NEG) begin
      mag_next = THETA_CLAMP;
      neg_next = 1'b1;
    end else if (s3_ang < 0) begin
      mag_next = MAG_W'(-s3_ang);
      neg_next = 1'b1;
    end else begin
      mag_next = MAG_W'(s3_ang);
      neg_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s4_keep  <= s3_keep;
    s4_range <= s3_range;
    s4_u     <= u_next;
    s4_q     <= q_prod[MOD_SHIFT+MOD_Q_W-1:MOD_SHIFT];
    s4_low   <= s3_ang[MOD_LOW_W-1:0];
    s4_mag   <= mag_next;
    s4_neg   <= neg_next;
  end

  // stage 5: angle modulo 360 deg, theta product
  assign rem_full = s4_u - MOD_U_W'(s4_q) * MOD_DIV;

  always_ff @(posedge clk) begin
    s5_keep  <= s4_keep;
    s5_range <= s4_range;
    s5_a     <= {rem_full[5:0], s4_low};
    s5_thp   <= 56'(s4_mag) * 56'(RAD_PER_DEG_Q32);
    s5_neg   <= s4_neg;
  end

  // stage 6: fold into [-90, 90] deg, seed x, round and saturate theta
  always_comb begin
    a_ext = $signed({1'b0, s5_a});
    if (s5_a >= DEG270) begin
      z_next    = Z_W'(a_ext - $signed({1'b0, DEG360}));
      flip_next = 1'b0;
    end else if (s5_a > DEG90) begin
      z_next    = Z_W'(a_ext - $signed({1'b0, DEG180}));
      flip_next = 1'b1;
    end else begin
      z_next    = $signed(s5_a);
      flip_next = 1'b0;
    end
    x_prod = 50'(s5_range) * 50'(GAIN_Q30);
    th_sum = {1'b0, s5_thp} + (57'd1 << 35);
    th_mag = th_sum[56:36];
    th_s   = s5_neg ? -$signed({1'b0, th_mag}) : $signed({1'b0, th_mag});
    if (th_s > 22'sd262143) begin
      th_next = 19'sd262143;
    end else if (th_s < -22'sd262144) begin
      th_next = -19'sd262144;
    end else begin
      th_next = THETA_W'(th_s);
    end
  end

  always_ff @(posedge clk) begin
    beat.keep  <= s5_keep;
    beat.flip  <= flip_next;
    beat.theta <= th_next;
    beat.x     <= $signed({2'b00, x_prod[49:16]});
    beat.y     <= '0;
    beat.z     <= z_next;
  end

endmodule

/* rtl/core/lsp2c_cordic_cell.sv */
// One CORDIC rotation cell: a single micro-rotation by atan(2^-SHIFT).
// Depends on lsp2c_pkg.
module lsp2c_cordic_cell import lsp2c_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  cell_beat_t in_beat,
  output logic       out_valid,
  output cell_beat_t out_beat
);

  localparam logic signed [Z_W-1:0] ATAN = atan_q20(SHIFT);

  logic signed [XY_W-1:0] xin, yin, dx, dy;
  logic signed [Z_W-1:0]  zin;

  assign xin = in_beat.x;
  assign yin = in_beat.y;
  assign zin = in_beat.z;
  // arithmetic shifts floor toward minus infinity
  assign dx  = yin >>> SHIFT;
  assign dy  = xin >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    out_beat.keep  <= in_beat.keep;
    out_beat.flip  <= in_beat.flip;
    out_beat.theta <= in_beat.theta;
    if (!zin[Z_W-1]) begin
      out_beat.x <= xin - dx;
      out_beat.y <= yin + dy;
      out_beat.z <= zin - ATAN;
    end else begin
      out_beat.x <= xin + dx;
      out_beat.y <= yin - dy;
      out_beat.z <= zin + ATAN;
    end
  end

endmodule

/* rtl/core/lsp2c_out.sv */
// Output stage: quadrant flip, rounding, saturation and reject zeroing.
// Depends on lsp2c_pkg.
module lsp2c_out import lsp2c_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  cell_beat_t                in_beat,
  output logic                      done,
  output logic                      point_kept,
  output logic signed [POS_W-1:0]   x_pos,
  output logic signed [POS_W-1:0]   y_pos,
  output logic signed [THETA_W-1:0] theta_rad
);

  // round at 2^13, drop 14 fraction bits, clamp to 21 bits
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [XY_W:0] v);
    logic signed [XY_W+1:0] s;
    logic signed [XY_W+1:0] t;
    s = {v[XY_W], v} + 38'sd8192;
    t = s >>> 14;
    if (t > 38'sd1048575) begin
      return 21'sd1048575;
    end else if (t < -38'sd1048576) begin
      return -21'sd1048576;
    end else begin
      return POS_W'(t);
    end
  endfunction

  logic signed [XY_W:0] xf, yf;

  // undo the 180 deg fold
  always_comb begin
    xf = {in_beat.x[XY_W-1], in_beat.x};
    yf = {in_beat.y[XY_W-1], in_beat.y};
    if (in_beat.flip) begin
      xf = -xf;
      yf = -yf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    point_kept <= in_beat.keep;
    if (in_beat.keep) begin
      x_pos     <= round_sat(xf);
      y_pos     <= round_sat(yf);
      theta_rad <= in_beat.theta;
    end else begin
      x_pos     <= '0;
      y_pos     <= '0;
      theta_rad <= '0;
    end
  end

endmodule

/* rtl/core/laser_scan_polar_to_cartesian.sv */
// Top level of the laser scan polar-to-cartesian converter.
// Uses lsp2c_pkg, lsp2c_front, lsp2c_cordic_cell, lsp2c_out and the macro header.
//
//   channel   signals                                   handshake
//   input     start, busy, range_sample, sample_index   start && !busy
//   result    done, point_kept, x_pos, y_pos, theta_rad done, one cycle
//   config    cfg_write, cfg_index, cfg_data            cfg_write
//
// One sample enters per clock while busy is low; each result passes through six
// front-end stages, one cell per CORDIC iteration and the output register.
// Reset clears all stage valids and loads the register defaults; busy is high
// only while reset is held. Results cannot be stalled and nothing stalls inside.
`include "laser_scan_polar_to_cartesian_macros.svh"

module laser_scan_polar_to_cartesian import lsp2c_pkg::*; #(
  parameter int MAX_SCAN_POINTS = 2048,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [RANGE_W-1:0]        range_sample,
  input  logic [IDX_W-1:0]          sample_index,
  output logic                      done,
  output logic                      point_kept,
  output logic signed [POS_W-1:0]   x_pos,
  output logic signed [POS_W-1:0]   y_pos,
  output logic signed [THETA_W-1:0] theta_rad,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [STEP_W-1:0]         cfg_data
);

  localparam int NCELL   = (CORDIC_STAGES > MAX_CELLS) ? MAX_CELLS : CORDIC_STAGES;
  localparam int LATENCY = NCELL + 7;

  // configuration registers
  logic signed [ANG_W-1:0] start_angle;
  logic signed [ANG_W-1:0] end_angle;
  logic [STEP_W-1:0]       angle_step;
  logic                    scan_direction;
  logic [DIST_W-1:0]       min_distance;
  logic [DIST_W-1:0]       max_distance;

  logic       accept;
  logic       result_zero;
  logic       chain_valid [NCELL+1];
  cell_beat_t chain_beat  [NCELL+1];

  assign busy   = rst;
  assign accept = start && !busy;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle    <= '0;
      end_angle      <= '0;
      angle_step     <= '0;
      scan_direction <= 1'b0;
      min_distance   <= '0;
      max_distance   <= '1;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_ANGLE:    start_angle    <= cfg_data[ANG_W-1:0];
        REG_END_ANGLE:      end_angle      <= cfg_data[ANG_W-1:0];
        REG_ANGLE_STEP:     angle_step     <= cfg_data;
        REG_SCAN_DIRECTION: scan_direction <= cfg_data[0];
        REG_MIN_DISTANCE:   min_distance   <= cfg_data[DIST_W-1:0];
        REG_MAX_DISTANCE:   max_distance   <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // gate, angle, fold and seed
  lsp2c_front #(
    .MAX_SCAN_POINTS(MAX_SCAN_POINTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .range_sample   (range_sample),
    .sample_index   (sample_index),
    .start_angle    (start_angle),
    .end_angle      (end_angle),
    .angle_step     (angle_step),
    .scan_direction (scan_direction),
    .min_distance   (min_distance),
    .max_distance   (max_distance),
    .beat_valid     (chain_valid[0]),
    .beat           (chain_beat[0])
  );

  // row of CORDIC cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    lsp2c_cordic_cell #(
      .SHIFT(k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_beat   (chain_beat[k]),
      .out_valid (chain_valid[k+1]),
      .out_beat  (chain_beat[k+1])
    );
  end

  // result register
  lsp2c_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[NCELL]),
    .in_beat    (chain_beat[NCELL]),
    .done       (done),
    .point_kept (point_kept),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .theta_rad  (theta_rad)
  );

  // all result fields zero
  assign result_zero = (x_pos == '0) && (y_pos == '0) && (theta_rad == '0);

  // checks
  `LSP2C_ASSERT_DELAY(a_fixed_latency, clk, rst, accept, LATENCY, done)
  `LSP2C_ASSERT_PAST(a_no_invented_result, clk, rst, done, start && !busy, LATENCY)
  `LSP2C_ASSERT_IMPLY(a_reject_zero, clk, rst, done && !point_kept, result_zero)

endmodule

/* test/tb_top.sv */
// Testbench for laser_scan_polar_to_cartesian: directed table, then random scans
// under many register settings, checked beat by beat against an in-bench predictor.
// Depends on lsp2c_pkg and the converter RTL only.
module tb_top;
  import lsp2c_pkg::*;

  localparam int MAX_POINTS = 2048;
  localparam int STAGES     = 16;
  localparam int LATENCY    = STAGES + 7;
  localparam int RANDOM_ITEMS = 1450;
  localparam int GAP_PCT    = 24;

  // index with no register behind it, written to check it is ignored
  localparam logic [2:0] REG_UNUSED = 3'd6;

  // predictor constants: angles in 2^-20 deg
  localparam longint ARC_90   = 64'sd94371840;
  localparam longint ARC_180  = 64'sd188743680;
  localparam longint ARC_270  = 64'sd283115520;
  localparam longint ARC_360  = 64'sd377487360;
  localparam longint GAIN_FX  = 64'sd652032874;
  localparam longint RAD_FX   = 64'sd74961321;
  localparam longint RANGE_FLOOR = 64'sd40;
  localparam longint ATAN_STEP [0:23] = '{
    64'sd47185920, 64'sd27855475, 64'sd14718068, 64'sd7471121, 64'sd3750058,
    64'sd1876857, 64'sd938658, 64'sd469357, 64'sd234682, 64'sd117342,
    64'sd58671, 64'sd29335, 64'sd14668, 64'sd7334, 64'sd3667, 64'sd1833,
    64'sd917, 64'sd458, 64'sd229, 64'sd115, 64'sd57, 64'sd29, 64'sd14, 64'sd7
  };

  typedef struct packed {
    logic                      kept;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [THETA_W-1:0] th;
  } point_t;

  // raw data written to each register, indexed by register
  typedef logic [REG_MAX_DISTANCE:0][STEP_W-1:0] reg_image_t;

  typedef struct packed {
    logic [2:0]         setting;
    logic [RANGE_W-1:0] rng;
    logic [IDX_W-1:0]   idx;
    logic               typed;
    point_t             pt;
  } sample_row_t;

  localparam point_t DROPPED = '0;
  localparam int NUM_ROWS = 23;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [RANGE_W-1:0]        range_sample;
  logic [IDX_W-1:0]          sample_index;
  logic                      done;
  logic                      point_kept;
  logic signed [POS_W-1:0]   x_pos;
  logic signed [POS_W-1:0]   y_pos;
  logic signed [THETA_W-1:0] theta_rad;
  logic                      cfg_write;
  logic [2:0]                cfg_index;
  logic [STEP_W-1:0]         cfg_data;

  // bench copy of the registers
  logic signed [ANG_W-1:0] scan_start;
  logic signed [ANG_W-1:0] scan_end;
  logic [STEP_W-1:0]       scan_step;
  logic                    scan_ccw;
  logic [DIST_W-1:0]       gate_min;
  logic [DIST_W-1:0]       gate_max;

  point_t points_due [$];
  int     errors = 0;
  int     kept_seen = 0;
  int     dropped_seen = 0;
  int     settings_used = 0;
  bit     gaps_on = 1'b1;

  // directed rows: typed expectations only for rejected samples
  sample_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{3'd0, 20'd0,       11'd0,    1'b1, DROPPED},
    '{3'd0, 20'd40,      11'd0,    1'b1, DROPPED},
    '{3'd0, 20'd41,      11'd0,    1'b0, DROPPED},
    '{3'd0, 20'hFFFFF,   11'd0,    1'b1, DROPPED},
    '{3'd0, 20'hFFFFE,   11'd2047, 1'b0, DROPPED},
    '{3'd0, 20'd4096,    11'd1234, 1'b0, DROPPED},
    '{3'd1, 20'd500,     11'd0,    1'b1, DROPPED},
    '{3'd1, 20'd501,     11'd0,    1'b0, DROPPED},
    '{3'd1, 20'd999,     11'd5,    1'b0, DROPPED},
    '{3'd1, 20'd1000,    11'd5,    1'b1, DROPPED},
    '{3'd1, 20'd41,      11'd0,    1'b1, DROPPED},
    '{3'd2, 20'hFFFFE,   11'd0,    1'b0, DROPPED},
    '{3'd2, 20'hFFFFE,   11'd2047, 1'b0, DROPPED},
    '{3'd2, 20'hAAAAA,   11'd1024, 1'b0, DROPPED},
    '{3'd2, 20'h55555,   11'h555,  1'b0, DROPPED},
    '{3'd3, 20'hFFFFE,   11'd0,    1'b0, DROPPED},
    '{3'd3, 20'd300000,  11'd2047, 1'b0, DROPPED},
    '{3'd3, 20'd300000,  11'd1023, 1'b0, DROPPED},
    '{3'd3, 20'd123456,  11'd512,  1'b0, DROPPED},
    '{3'd3, 20'd77,      11'h2AA,  1'b0, DROPPED},
    '{3'd4, 20'hFFFFE,   11'd0,    1'b1, DROPPED},
    '{3'd4, 20'd524288,  11'd100,  1'b1, DROPPED},
    '{3'd4, 20'd0,       11'd2047, 1'b1, DROPPED}
  };

  laser_scan_polar_to_cartesian #(
    .MAX_SCAN_POINTS(MAX_POINTS),
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .range_sample(range_sample),
    .sample_index(sample_index),
    .done(done),
    .point_kept(point_kept),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .theta_rad(theta_rad),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  // range gate, beam angle, theta and CORDIC rotation for one sample
  function automatic point_t polar_to_xy(input logic [RANGE_W-1:0] rng,
                                         input logic [IDX_W-1:0] idx);
    point_t p;
    longint ang, lim, a, mag, th, z, x, y, dx, dy, xr, yr;
    bit flip;
    p = '0;
    flip = 1'b0;
    if (longint'(rng) <= RANGE_FLOOR || rng <= gate_min || rng >= gate_max ||
        idx >= MAX_POINTS)
      return p;

    if (!scan_ccw)
      ang = longint'(scan_start) * 256 + longint'(idx) * longint'(scan_step);
    else
      ang = longint'(scan_end) * 256 - longint'(idx) * longint'(scan_step);

    // theta: clamp, scale to radians, round half away from zero
    lim = 64'sd1 <<< 28;
    a = (ang < -lim) ? -lim : ((ang > lim) ? lim : ang);
    mag = (a < 0) ? -a : a;
    mag = (mag * RAD_FX + (64'sd1 <<< 35)) >>> 36;
    th = (a < 0) ? -mag : mag;
    th = (th < -262144) ? -262144 : ((th > 262143) ? 262143 : th);

    // fold into [-90, 90] deg, remember a half turn
    a = ang % ARC_360;
    if (a < 0)
      a += ARC_360;
    if (a >= ARC_270) begin
      z = a - ARC_360;
    end else if (a > ARC_90) begin
      z = a - ARC_180;
      flip = 1'b1;
    end else begin
      z = a;
    end

    x = (longint'(rng) * GAIN_FX) >>> 16;
    y = 0;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_STEP[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_STEP[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end

    // round off the 14 extra fraction bits, saturate
    xr = (x + 8192) >>> 14;
    yr = (y + 8192) >>> 14;
    xr = (xr < -1048576) ? -1048576 : ((xr > 1048575) ? 1048575 : xr);
    yr = (yr < -1048576) ? -1048576 : ((yr > 1048575) ? 1048575 : yr);

    p.kept = 1'b1;
    p.x = xr[POS_W-1:0];
    p.y = yr[POS_W-1:0];
    p.th = th[THETA_W-1:0];
    return p;
  endfunction

  // one register write; leaves cfg_write high for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [STEP_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_START_ANGLE:    scan_start = data[ANG_W-1:0];
      REG_END_ANGLE:      scan_end = data[ANG_W-1:0];
      REG_ANGLE_STEP:     scan_step = data;
      REG_SCAN_DIRECTION: scan_ccw = data[0];
      REG_MIN_DISTANCE:   gate_min = data[DIST_W-1:0];
      REG_MAX_DISTANCE:   gate_max = data[DIST_W-1:0];
      default: ;
    endcase
  endtask

  // hold off new samples until every point in flight is out
  task automatic settle_pipeline();
    start <= 1'b0;
    while (points_due.size() != 0)
      @(posedge clk);
  endtask

  // drain, then write every register (and the unused index)
  task automatic load_settings(input reg_image_t img);
    settle_pipeline();
    for (int r = 0; r <= REG_MAX_DISTANCE; r++)
      write_reg(3'(r), img[r]);
    write_reg(REG_UNUSED, STEP_W'($urandom));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic [IDX_W-1:0] idx,
                             input logic typed, input point_t typed_pt);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    range_sample <= rng;
    sample_index <= idx;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    points_due.insert(points_due.size(), typed ? typed_pt : polar_to_xy(rng, idx));
  endtask

  function automatic logic [STEP_W-1:0] pick_angle();
    case ($urandom_range(5))
      0: return STEP_W'(737280);
      1: return STEP_W'(-737280);
      2: return '0;
      3: return STEP_W'($urandom);
      default: return STEP_W'(int'($urandom_range(1474560)) - 737280);
    endcase
  endfunction

  function automatic reg_image_t pick_settings();
    reg_image_t img;
    img[REG_START_ANGLE] = pick_angle();
    img[REG_END_ANGLE] = pick_angle();
    case ($urandom_range(5))
      0: img[REG_ANGLE_STEP] = '0;
      1: img[REG_ANGLE_STEP] = '1;
      2: img[REG_ANGLE_STEP] = STEP_W'($urandom);
      3: img[REG_ANGLE_STEP] = STEP_W'($urandom_range(400000));
      default: img[REG_ANGLE_STEP] = STEP_W'($urandom_range(150000, 200000));
    endcase
    img[REG_SCAN_DIRECTION] = ($urandom_range(3) == 0) ? STEP_W'($urandom)
                                                       : STEP_W'($urandom_range(1));
    case ($urandom_range(5))
      0: begin
        img[REG_MIN_DISTANCE] = STEP_W'($urandom);
        img[REG_MAX_DISTANCE] = STEP_W'($urandom);
      end
      1: begin
        img[REG_MIN_DISTANCE] = '0;
        img[REG_MAX_DISTANCE] = '1;
      end
      default: begin
        img[REG_MIN_DISTANCE] = STEP_W'($urandom_range(200));
        img[REG_MAX_DISTANCE] = STEP_W'(1048575 - $urandom_range(300000));
      end
    endcase
    return img;
  endfunction

  // mostly ranges inside the gates, the rest edges and noise
  function automatic logic [RANGE_W-1:0] pick_range();
    int lo, hi;
    lo = ((gate_min > 40) ? int'(gate_min) : 40) + 1;
    hi = int'(gate_max) - 1;
    case ($urandom_range(9))
      0: return RANGE_W'($urandom);
      1: begin
        case ($urandom_range(7))
          0: return '0;
          1: return RANGE_W'(40);
          2: return RANGE_W'(41);
          3: return gate_min;
          4: return gate_min + 1'b1;
          5: return gate_max;
          6: return gate_max - 1'b1;
          default: return '1;
        endcase
      end
      default: begin
        if (lo <= hi)
          return RANGE_W'($urandom_range(hi, lo));
        return RANGE_W'($urandom);
      end
    endcase
  endfunction

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && done) begin
      if (points_due.size() == 0) begin
        $error("result beat with no sample in flight");
        errors++;
      end else begin
        want = points_due.pop_front();
        if (point_kept !== want.kept) begin
          $error("point_kept: expected %0d, got %0d", want.kept, point_kept);
          errors++;
        end
        if (x_pos !== want.x) begin
          $error("x_pos: expected %0d, got %0d", want.x, x_pos);
          errors++;
        end
        if (y_pos !== want.y) begin
          $error("y_pos: expected %0d, got %0d", want.y, y_pos);
          errors++;
        end
        if (theta_rad !== want.th) begin
          $error("theta_rad: expected %0d, got %0d", want.th, theta_rad);
          errors++;
        end
        if (want.kept)
          kept_seen++;
        else
          dropped_seen++;
      end
    end
  end

  initial begin : run
    reg_image_t directed_img [1:4];
    int phase;
    int sent;
    int count;
    logic [2:0] cur_setting;

    rst = 1'b1;
    start = 1'b0;
    range_sample = '0;
    sample_index = '0;
    cfg_write = 1'b0;
    cfg_index = REG_START_ANGLE;
    cfg_data = '0;

    // register state after reset
    scan_start = '0;
    scan_end = '0;
    scan_step = '0;
    scan_ccw = 1'b0;
    gate_min = '0;
    gate_max = '1;

    // directed settings: tight gates, full-circle extremes, masked data, all closed
    directed_img[1] = '0;
    directed_img[1][REG_START_ANGLE] = STEP_W'(737280);
    directed_img[1][REG_MIN_DISTANCE] = STEP_W'(500);
    directed_img[1][REG_MAX_DISTANCE] = STEP_W'(1000);
    directed_img[2] = '0;
    directed_img[2][REG_START_ANGLE] = STEP_W'(-737280);
    directed_img[2][REG_END_ANGLE] = STEP_W'(737280);
    directed_img[2][REG_ANGLE_STEP] = '1;
    directed_img[2][REG_MAX_DISTANCE] = STEP_W'(1048575);
    directed_img[3] = '0;
    directed_img[3][REG_START_ANGLE] = '1;
    directed_img[3][REG_END_ANGLE] = STEP_W'(-737280);
    directed_img[3][REG_ANGLE_STEP] = STEP_W'(184320);
    directed_img[3][REG_SCAN_DIRECTION] = '1;
    directed_img[3][REG_MAX_DISTANCE] = '1;
    directed_img[4] = '0;
    directed_img[4][REG_MIN_DISTANCE] = STEP_W'(1048575);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    cur_setting = 3'd0;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].setting != cur_setting) begin
        cur_setting = directed_rows[k].setting;
        load_settings(directed_img[cur_setting]);
      end
      send_sample(directed_rows[k].rng, directed_rows[k].idx,
                  directed_rows[k].typed, directed_rows[k].pt);
    end

    // random scans, one register setting per phase; phase 2 runs without gaps
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      load_settings(pick_settings());
      gaps_on = (phase != 2);
      count = (phase == 2) ? 300 : $urandom_range(40, 220);
      for (int n = 0; n < count && sent < RANDOM_ITEMS; n++) begin
        send_sample(pick_range(), IDX_W'($urandom_range(MAX_POINTS - 1)), 1'b0, DROPPED);
        sent++;
      end
      phase++;
    end
    gaps_on = 1'b1;

    settle_pipeline();
    repeat (2 * LATENCY) @(posedge clk);

    $display("covered %0d register settings, %0d random samples after the directed table",
             settings_used, sent);
    $display("points kept %0d, points dropped %0d, mismatches %0d",
             kept_seen, dropped_seen, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
